/* hdl/aicd_pkg.sv */
// Package for the ARM instruction class decoder.
// Holds the mask/expected class table, its size and the result index width.
// No dependencies.
package aicd_pkg;

  localparam int CLASS_COUNT = 90;
  localparam int IDX_W       = 7;
  localparam int INSTR_W     = 32;

  typedef struct packed {
    logic [INSTR_W-1:0] mask;
    logic [INSTR_W-1:0] expect_val;
  } pattern_t;

  // Class table in priority order: the earliest matching entry wins
  localparam pattern_t CLASS_TABLE [CLASS_COUNT] = '{
    // branches: BL, BLX(2), BX
    '{32'h0e000000, 32'h0a000000}, '{32'h0ffffff0, 32'h012fff30},
    '{32'h0ffffff0, 32'h012fff10},
    // multiplies
    '{32'h0fe000f0, 32'h00200090}, '{32'h0fe0f0f0, 32'h00000090},
    '{32'h0ff00090, 32'h01000080}, '{32'h0ff0f0d0, 32'h0700f010},
    '{32'h0ff000d0, 32'h07000010}, '{32'h0fe000f0, 32'h00e00090},
    '{32'h0ff00090, 32'h01400080}, '{32'h0ff000d0, 32'h07400010},
    '{32'h0ff000b0, 32'h01200080}, '{32'h0ff0f0d0, 32'h0700f050},
    '{32'h0ff000d0, 32'h07000050}, '{32'h0ff000d0, 32'h07400050},
    '{32'h0ff0f0d0, 32'h0750f010}, '{32'h0ff000d0, 32'h07500010},
    '{32'h0ff000d0, 32'h075000d0}, '{32'h0ff0f090, 32'h01600080},
    '{32'h0fe000f0, 32'h00c00090}, '{32'h0ff0f0b0, 32'h012000a0},
    '{32'h0ff000f0, 32'h00400090}, '{32'h0fe000f0, 32'h00a00090},
    '{32'h0fe000f0, 32'h00800090},
    // sign and zero extends
    '{32'h0fff03f0, 32'h068f0070}, '{32'h0ff003f0, 32'h06800070},
    '{32'h0fff03f0, 32'h06af0070}, '{32'h0ff003f0, 32'h06a00070},
    '{32'h0fff03f0, 32'h06bf0070}, '{32'h0ff003f0, 32'h06b00070},
    '{32'h0fff03f0, 32'h06cf0070}, '{32'h0ff003f0, 32'h06c00070},
    '{32'h0fff03f0, 32'h06ef0070}, '{32'h0ff003f0, 32'h06e00070},
    '{32'h0fff03f0, 32'h06ff0070}, '{32'h0ff003f0, 32'h06f00070},
    // loads and stores
    '{32'h0d700000, 32'h04300000}, '{32'h0c500000, 32'h04100000},
    '{32'h0d700000, 32'h04700000}, '{32'h0c500000, 32'h04500000},
    '{32'h0e1000f0, 32'h000000d0}, '{32'h0ff00fff, 32'h01900f9f},
    '{32'h0e1000f0, 32'h001000b0}, '{32'h0e1000f0, 32'h001000d0},
    '{32'h0e1000f0, 32'h001000f0}, '{32'h0d700000, 32'h04200000},
    '{32'h0c500000, 32'h04000000}, '{32'h0c700000, 32'h04600000},
    '{32'h0c500000, 32'h04400000}, '{32'h0e1000f0, 32'h000000f0},
    '{32'h0ff00ff0, 32'h01800f90}, '{32'h0e1000f0, 32'h000000b0},
    // data processing
    '{32'h0de00000, 32'h00a00000}, '{32'h0de00000, 32'h00800000},
    '{32'h0de00000, 32'h00000000}, '{32'h0de00000, 32'h01c00000},
    '{32'h0df0f000, 32'h01700000}, '{32'h0df0f000, 32'h01500000},
    '{32'h0de00000, 32'h00200000}, '{32'h0de00000, 32'h01a00000},
    '{32'h0de00000, 32'h01e00000}, '{32'h0de00000, 32'h01800000},
    '{32'h0de00000, 32'h00600000}, '{32'h0de00000, 32'h00e00000},
    '{32'h0de00000, 32'h00c00000}, '{32'h0de00000, 32'h00400000},
    '{32'h0df0f000, 32'h01300000}, '{32'h0df00000, 32'h01100000},
    // CLZ and semaphores
    '{32'h0fff0ff0, 32'h016f0f10}, '{32'h0ff00ff0, 32'h01400090},
    '{32'h0ff00ff0, 32'h01000090},
    // coprocessor
    '{32'h0ff00000, 32'h0c500000}, '{32'h0f000010, 32'h0e000000},
    '{32'h0e100000, 32'h0c100000}, '{32'h0f100010, 32'h0e000010},
    '{32'h0ff00000, 32'h0c400000}, '{32'h0f100010, 32'h0e100010},
    '{32'h0e100000, 32'h0c000000},
    // status register access
    '{32'h0fbf0fff, 32'h010f0000}, '{32'h0fa0f000, 32'h0320f000},
    '{32'h0fa0fff0, 32'h0120f000}, '{32'hfff1fd20, 32'hf1000000},
    '{32'hfffffdff, 32'hf1010000},
    // load and store multiple
    '{32'h0e500000, 32'h08100000}, '{32'h0e708000, 32'h08500000},
    '{32'h0e508000, 32'h08508000}, '{32'h0e500000, 32'h08000000},
    '{32'h0e700000, 32'h08400000},
    // exception generating: BKPT, SWI
    '{32'hfff000f0, 32'he1200070}, '{32'h0f000000, 32'h0f000000}
  };

endpackage

/* hdl/arm_instruction_class_decoder_core.sv */
// ARM instruction class decoder: input register, table match and priority
// encode, result register. Depends on aicd_pkg.
//
// An accepted instruction passes through the input register and then the
// result register, where the result can be taken.
// Throughput: one item per cycle while out_stall is low, as the match and
// priority encode between the two registers are combinational.
// Reset (rst, synchronous) clears both stage valid flags; no item survives.
module arm_instruction_class_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [aicd_pkg::INSTR_W-1:0] instruction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [aicd_pkg::IDX_W-1:0]  class_index
);
  import aicd_pkg::*;

  logic               in_reg_valid;
  logic [INSTR_W-1:0] in_reg_instr;
  logic               out_load;
  logic               in_load;
  logic               hit_next;
  logic [IDX_W-1:0]   class_index_next;

  // Advance the result stage when it is empty or being taken
  assign out_load = !out_valid || !out_stall;
  // Take a new item when the input stage is empty or moving on
  assign in_load  = !in_reg_valid || out_load;
  assign in_stall = !in_load;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_load) begin
      in_reg_valid <= in_valid;
    end
    if (in_load && in_valid) begin
      in_reg_instr <= instruction;
    end
  end

  // Match every entry, lowest index wins
  always_comb begin
    hit_next         = 1'b0;
    class_index_next = '0;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if ((in_reg_instr & CLASS_TABLE[i].mask) == CLASS_TABLE[i].expect_val) begin
        hit_next         = 1'b1;
        class_index_next = IDX_W'(i);
      end
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_reg_valid;
    end
    if (out_load && in_reg_valid) begin
      hit         <= hit_next;
      class_index <= class_index_next;
    end
  end

  // A miss always reports class zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (class_index == '0))
    else $error("miss with non-zero class index");

  // A hit never points past the table
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (class_index < IDX_W'(CLASS_COUNT)))
    else $error("class index beyond table");

  // Input is held off only when both stages are full and the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // Reset leaves no result pending
  assert property (@(posedge clk)
    rst |=> (!out_valid && !in_reg_valid))
    else $error("valid flag set after reset");

endmodule
